// File: sv/dsaa_pkg.sv
// dsaa_pkg: shared types, constants and helper functions of the downscale block
// used by every module of block_downscale_antialias_unit; depends on nothing
`default_nettype none

package dsaa_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_FACTOR   = 8;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int SUM_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int DIM_W     = 13;
    localparam int EXT_W     = DIM_W + 1;
    localparam int FACTOR_W  = 4;
    localparam int CNT_W     = FACTOR_W;
    localparam int PIX_W     = 8;
    localparam int ADD_W     = PIX_W + 2;
    localparam int SUM_W     = 14;
    localparam int CH_N      = 3;
    localparam int DATA_W    = CH_N * PIX_W;
    localparam int MEM_W     = CH_N * SUM_W;
    localparam int IDX_W     = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;
    localparam logic [IDX_W-1:0] REG_COLOUR_MODE  = 2'd3;

    localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(HEIGHT_LIMIT);
    localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(3);
    localparam logic                COLOUR_RST = 1'b0;

    // divider kinds
    localparam logic [1:0] DIV_BY_4  = 2'd0;
    localparam logic [1:0] DIV_BY_16 = 2'd1;
    localparam logic [1:0] DIV_BY_64 = 2'd2;
    localparam logic [1:0] DIV_BY_36 = 2'd3;

    // x / 36 == (x * RECIP36) >> RECIP_SHIFT for every x below 2**SUM_W
    localparam int         RECIP_SHIFT = 20;
    localparam int         RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP36 = RECIP_W'((2 ** RECIP_SHIFT + 35) / 36);
    localparam int         PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic              use_px;
        logic              first;
        logic              emit;
        logic              last_img;
        logic [1:0]        div_kind;
        logic [1:0]        wt_shift;
        logic [ADDR_W-1:0] addr;
    } dsaa_item_t;

    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic [1:0]                  div_kind;
        logic [CH_N-1:0][SUM_W-1:0]  sums;
    } dsaa_sum_t;

    // 1 2 1 / 2 4 2 / 1 2 1 as a left shift
    function automatic logic [1:0] gauss_shift(input logic [1:0] r, input logic [1:0] c);
        logic [1:0] s;
        s = {1'b0, (r == 2'd1)} + {1'b0, (c == 2'd1)};
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/dsaa_raster_ctrl.sv
// dsaa_raster_ctrl: configuration registers and raster / block position counters
// builds the per-word control item; depends on dsaa_pkg
`default_nettype none

module dsaa_raster_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dsaa_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [dsaa_pkg::DIM_W-1:0]    cfg_data,
    input  wire logic                          accept,
    output dsaa_pkg::dsaa_item_t               item,
    output logic                               colour_mode
);
    import dsaa_pkg::*;

    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                colour_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  cib_reg, cib_next;
    logic [CNT_W-1:0]  rib_reg, rib_next;
    logic [ADDR_W-1:0] bcol_reg, bcol_next;
    logic [DIM_W-1:0]  bx0_reg, bx0_next;
    logic [DIM_W-1:0]  by0_reg, by0_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             col_last, row_last, cib_wrap, rib_wrap;
    logic             factor_ok, inside_x, inside_y, last_x, last_y;
    logic [EXT_W-1:0] x_end, y_end, fext;
    logic [FACTOR_W-1:0] fm1;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(HEIGHT_LIMIT)) begin
            h_eff = DIM_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign factor_ok = (factor_reg == FACTOR_W'(3)) ||
                       (factor_reg >= FACTOR_W'(2) && !factor_reg[0] &&
                        factor_reg <= FACTOR_W'(MAX_FACTOR));
    assign fm1  = factor_reg - FACTOR_W'(1);
    assign fext = EXT_W'(factor_reg);

    assign col_last = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign row_last = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
    assign cib_wrap = !((EXT_W'(cib_reg) + EXT_W'(1)) < fext);
    assign rib_wrap = !((EXT_W'(rib_reg) + EXT_W'(1)) < fext);

    assign x_end    = EXT_W'(bx0_reg) + fext;
    assign y_end    = EXT_W'(by0_reg) + fext;
    assign inside_x = x_end <= EXT_W'(w_eff);
    assign inside_y = y_end <= EXT_W'(h_eff);
    assign last_x   = (x_end + fext) > EXT_W'(w_eff);
    assign last_y   = (y_end + fext) > EXT_W'(h_eff);

    always_comb begin
        item.use_px   = factor_ok && inside_x && inside_y;
        item.first    = (cib_reg == '0) && (rib_reg == '0);
        item.emit     = (cib_reg == fm1) && (rib_reg == fm1);
        item.last_img = last_x && last_y;
        item.addr     = bcol_reg;
        item.wt_shift = (factor_reg == FACTOR_W'(3)) ? gauss_shift(rib_reg[1:0], cib_reg[1:0])
                                                      : 2'd0;
        unique case (factor_reg)
            FACTOR_W'(2): item.div_kind = DIV_BY_4;
            FACTOR_W'(6): item.div_kind = DIV_BY_36;
            FACTOR_W'(8): item.div_kind = DIV_BY_64;
            default:      item.div_kind = DIV_BY_16;
        endcase
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        bcol_next = bcol_reg;
        bx0_next  = bx0_reg;
        by0_next  = by0_reg;
        if (accept) begin
            if (cib_wrap) begin
                cib_next  = '0;
                bcol_next = bcol_reg + ADDR_W'(1);
                bx0_next  = bx0_reg + DIM_W'(factor_reg);
            end else begin
                cib_next = cib_reg + CNT_W'(1);
            end
            if (!col_last) begin
                col_next = col_reg + COL_W'(1);
            end else begin
                col_next  = '0;
                cib_next  = '0;
                bcol_next = '0;
                bx0_next  = '0;
                if (rib_wrap) begin
                    rib_next = '0;
                    by0_next = by0_reg + DIM_W'(factor_reg);
                end else begin
                    rib_next = rib_reg + CNT_W'(1);
                end
                if (!row_last) begin
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    row_next = '0;
                    rib_next = '0;
                    by0_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            factor_reg <= FACTOR_RST;
            colour_reg <= COLOUR_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            bcol_reg   <= '0;
            bx0_reg    <= '0;
            by0_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_SCALE_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_COLOUR_MODE:  colour_reg <= cfg_data[0];
                default: ;
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bcol_reg <= '0;
            bx0_reg  <= '0;
            by0_reg  <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
            bcol_reg <= bcol_next;
            bx0_reg  <= bx0_next;
            by0_reg  <= by0_next;
        end
    end

    assign colour_mode = colour_reg;

endmodule

`default_nettype wire

// File: sv/dsaa_accum.sv
// dsaa_accum: column sum memory with read-modify-write and last-write bypass
// depends on dsaa_pkg
`default_nettype none

module dsaa_accum (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        adv,
    input  wire logic                                        in_valid,
    input  dsaa_pkg::dsaa_item_t                             item,
    input  wire logic [dsaa_pkg::CH_N-1:0][dsaa_pkg::PIX_W-1:0] px,
    output dsaa_pkg::dsaa_sum_t                              sum_out
);
    import dsaa_pkg::*;

    logic [MEM_W-1:0] mem [SUM_DEPTH];

    logic                       s1_valid_reg;
    dsaa_item_t                 s1_item_reg;
    logic [CH_N-1:0][ADD_W-1:0] s1_add_reg;
    logic [MEM_W-1:0]           rd_data_reg;

    logic                       lw_valid_reg;
    logic [ADDR_W-1:0]          lw_addr_reg;
    logic [MEM_W-1:0]           lw_data_reg;

    logic [MEM_W-1:0]           old_data;
    logic [CH_N-1:0][SUM_W-1:0] new_sums;
    logic                       wr_en;

    assign wr_en    = adv && s1_valid_reg;
    assign old_data = (lw_valid_reg && lw_addr_reg == s1_item_reg.addr) ? lw_data_reg
                                                                         : rd_data_reg;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            if (s1_item_reg.first) begin
                new_sums[c] = SUM_W'(s1_add_reg[c]);
            end else begin
                new_sums[c] = old_data[c*SUM_W +: SUM_W] + SUM_W'(s1_add_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            rd_data_reg <= mem[item.addr];
        end
        if (wr_en) begin
            mem[s1_item_reg.addr] <= new_sums;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= item;
            for (int c = 0; c < CH_N; c++) begin
                s1_add_reg[c] <= ADD_W'(px[c]) << item.wt_shift;
            end
        end
        if (wr_en) begin
            lw_addr_reg <= s1_item_reg.addr;
            lw_data_reg <= new_sums;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= in_valid;
            end
            if (wr_en) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        sum_out.valid    = s1_valid_reg && s1_item_reg.emit;
        sum_out.last     = s1_item_reg.last_img;
        sum_out.div_kind = s1_item_reg.div_kind;
        sum_out.sums     = new_sums;
    end

endmodule

`default_nettype wire

// File: sv/dsaa_divide.sv
// dsaa_divide: block sum register, division by the block weight and output register
// depends on dsaa_pkg
`default_nettype none

module dsaa_divide (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  dsaa_pkg::dsaa_sum_t                 sum_in,
    output logic                                out_valid,
    output logic [dsaa_pkg::DATA_W-1:0]         out_data,
    output logic                                out_last
);
    import dsaa_pkg::*;

    dsaa_sum_t                  s2_reg;
    logic                       out_valid_reg;
    logic [DATA_W-1:0]          out_data_reg;
    logic                       out_last_reg;
    logic [CH_N-1:0][PIX_W-1:0] quot;
    logic [CH_N-1:0][PROD_W-1:0] prod;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            prod[c] = PROD_W'(s2_reg.sums[c]) * PROD_W'(RECIP36);
            case (s2_reg.div_kind)
                DIV_BY_4:  quot[c] = PIX_W'(s2_reg.sums[c] >> 2);
                DIV_BY_16: quot[c] = PIX_W'(s2_reg.sums[c] >> 4);
                DIV_BY_64: quot[c] = PIX_W'(s2_reg.sums[c] >> 6);
                default:   quot[c] = PIX_W'(prod[c] >> RECIP_SHIFT);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg.last     <= sum_in.last;
            s2_reg.div_kind <= sum_in.div_kind;
            s2_reg.sums     <= sum_in.sums;
            out_data_reg    <= quot;
            out_last_reg    <= s2_reg.last;
        end
        if (!aresetn) begin
            s2_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_reg.valid  <= sum_in.valid;
            out_valid_reg <= s2_reg.valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: sv/block_downscale_antialias_unit.sv
// block_downscale_antialias_unit: top level of the integer-factor image downscaler
// path: each result passes the s1, s2 and output registers before it drives m_tvalid
// throughput: one word per cycle, set by the sum memory read-modify-write with bypass
// s_tready drops only while a finished result waits on m_tready
// reset: synchronous active low; registers go to 4096 x 4096, factor 3, grey
// the sum memory is not cleared; each block column is written at its top-left pixel
`default_nettype none

module block_downscale_antialias_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [dsaa_pkg::DATA_W-1:0] s_tdata,   // red_or_grey, green_in, blue_in
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dsaa_pkg::DATA_W-1:0]      m_tdata,   // out_red_or_grey, out_green, out_blue
    output logic                             m_tlast,
    input  wire logic                        cfg_wr_en,
    input  wire logic [dsaa_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [dsaa_pkg::DIM_W-1:0]  cfg_data
);
    import dsaa_pkg::*;

    logic                       adv;
    logic                       s_accept;
    logic                       colour_mode;
    dsaa_item_t                 item;
    dsaa_sum_t                  sum_s1;
    logic [CH_N-1:0][PIX_W-1:0] px;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        px[0] = s_tdata[PIX_W-1:0];
        px[1] = colour_mode ? s_tdata[2*PIX_W-1:PIX_W] : '0;
        px[2] = colour_mode ? s_tdata[3*PIX_W-1:2*PIX_W] : '0;
    end

    dsaa_raster_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (s_accept),
        .item        (item),
        .colour_mode (colour_mode)
    );

    dsaa_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_accept && item.use_px),
        .item     (item),
        .px       (px),
        .sum_out  (sum_s1)
    );

    dsaa_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .sum_in    (sum_s1),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// File: sv/dsaa_checker.sv
// dsaa_checker: port-level assertions for block_downscale_antialias_unit
// bound to the top level; depends on dsaa_pkg
`default_nettype none

module dsaa_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [dsaa_pkg::DATA_W-1:0] m_tdata,
    input wire logic                        m_tlast
);
    import dsaa_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_in_blocked_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("input word taken while output stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind block_downscale_antialias_unit dsaa_checker u_dsaa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
